@@ src/ial_pkg.sv @@
// shared types and constants for the indexed array list
package ial_pkg;

    localparam int unsigned DEF_CAPACITY   = 16;
    localparam int unsigned DEF_WORD_WIDTH = 32;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_GET    = 3'd4
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

endpackage

@@ src/ial_req_if.sv @@
// request channel of the indexed array list
interface ial_req_if;
    logic                        valid;
    logic                        ready;
    logic [ial_pkg::ACTION_W-1:0] action;
    logic [ial_pkg::POS_W-1:0]    position;
    logic [ial_pkg::DATA_W-1:0]   word_in;

    modport source (output valid, output action, output position, output word_in,
                    input ready);
    modport sink   (input valid, input action, input position, input word_in,
                    output ready);
endinterface

@@ src/ial_rsp_if.sv @@
// result channel of the indexed array list
interface ial_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ial_pkg::DATA_W-1:0]  word_out;
    logic [ial_pkg::ERR_W-1:0]   error_code;
    logic [ial_pkg::COUNT_W-1:0] entry_count;
    logic                        is_full;
    logic                        is_empty;

    modport source (output valid, output word_out, output error_code,
                    output entry_count, output is_full, output is_empty,
                    input ready);
    modport sink   (input valid, input word_out, input error_code,
                    input entry_count, input is_full, input is_empty,
                    output ready);
endinterface

@@ src/ial_cell.sv @@
// one list slot: holds an entry and trades it with its neighbors on a shift
module ial_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned SW    = 32,
    parameter int unsigned IW    = 4
) (
    input  logic              i_clk,
    input  ial_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_slot,
    input  logic [SW-1:0]     i_word,
    input  logic [SW-1:0]     i_prev,
    input  logic [SW-1:0]     i_next,
    output logic [SW-1:0]     o_data
);
    import ial_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [SW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_INSERT: begin
                if (MY_IDX == i_slot) begin
                    r_data <= i_word;
                end else if (MY_IDX > i_slot) begin
                    r_data <= i_prev;
                end
            end
            CELL_REMOVE: begin
                // entries at and above the slot pull from the next cell up
                if (MY_IDX >= i_slot) begin
                    r_data <= i_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
endmodule

@@ src/indexed_array_list_core.sv @@
// top level of the indexed array list: request decode, cell row and result register
//
// Requests arrive on i_req (action, position, word_in) with a valid/ready
// handshake; one result per request leaves on o_rsp (word_out, error_code,
// entry_count, is_full, is_empty). Actions: push, pop, insert at position,
// remove at position, get. Insert and remove move every later entry by one
// slot in the same cycle, since each cell of the row loads from its neighbor.
// A request is decoded and carried out in the cycle of its transfer; its
// result sits in the output register from the next cycle on, and one request
// is taken per cycle while the receiver takes each result.
// The output register takes a new result in the cycle the old one is
// transferred, so a stalled receiver holds back i_req.ready only while an
// untaken result waits. Reset clears the count and the result valid flag;
// entry contents are not cleared, as only entries below the count are read.
module indexed_array_list_core #(
    parameter int unsigned CAPACITY   = ial_pkg::DEF_CAPACITY,
    parameter int unsigned WORD_WIDTH = ial_pkg::DEF_WORD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ial_req_if.sink   i_req,
    ial_rsp_if.source o_rsp
);
    import ial_pkg::*;

    localparam int unsigned SW   = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
    localparam int unsigned IW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    logic [DATA_W-1:0] r_word_out;
    t_err            r_err;
    logic [COUNT_W-1:0] r_entry_count;
    logic            r_is_full;
    logic            r_is_empty;

    logic            w_accept;
    t_cell_op        w_op;
    logic [IW-1:0]   w_slot;
    t_err            w_err;
    logic [SW-1:0]   w_read;
    logic [SW-1:0]   w_word;
    logic [CMPW-1:0] w_pos;
    logic [CMPW-1:0] w_cnt;
    logic [CMPW-1:0] w_next_cnt;
    logic [SW-1:0]   w_cell [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_word      = i_req.word_in[SW-1:0];
    assign w_pos       = CMPW'(i_req.position);
    assign w_cnt       = CMPW'(r_count);

    // request decode
    always_comb begin
        w_op    = CELL_HOLD;
        w_slot  = '0;
        w_err   = ERR_OK;
        w_read  = '0;
        n_count = r_count;
        unique case (t_action'(i_req.action))
            ACT_PUSH: begin
                if (w_cnt == CAP_C) begin
                    w_err = ERR_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    w_slot  = w_cnt[IW-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            ACT_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            ACT_INSERT: begin
                if (w_pos > CAP_C) begin
                    w_err = ERR_RANGE;
                end else if (w_cnt == CAP_C) begin
                    w_err = ERR_FULL;
                end else if (w_pos > w_cnt) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_op    = CELL_INSERT;
                    w_slot  = w_pos[IW-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_op    = CELL_REMOVE;
                    w_slot  = w_pos[IW-1:0];
                    n_count = r_count - 1'b1;
                end
            end
            ACT_GET: begin
                if (w_pos >= w_cnt) begin
                    w_err = ERR_RANGE;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_pos[IW-1:0] == IW'(i)) begin
                            w_read = w_cell[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_next_cnt = CMPW'(n_count);

    // row of cells, each loading from its lower or upper neighbor on a shift
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SW-1:0] w_prev;
        logic [SW-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_word;
        end else begin : g_mid
            assign w_prev = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_cell[g];
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end

        ial_cell #(
            .INDEX (g),
            .SW    (SW),
            .IW    (IW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_accept ? w_op : CELL_HOLD),
            .i_slot (w_slot),
            .i_word (w_word),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word_out    <= DATA_W'(w_read);
            r_err         <= w_err;
            r_entry_count <= w_next_cnt[COUNT_W-1:0];
            r_is_full     <= (w_next_cnt == CAP_C);
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.word_out    = r_word_out;
    assign o_rsp.error_code  = r_err;
    assign o_rsp.entry_count = r_entry_count;
    assign o_rsp.is_full     = r_is_full;
    assign o_rsp.is_empty    = r_is_empty;
endmodule

@@ test/indexed_array_list_core_tb.sv @@
`timescale 1ns / 1ps
// testbench for indexed_array_list_core: directed list edits and random traffic, checked per result

module indexed_array_list_core_tb;
    import ial_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int ACTION_MAX   = (1 << ACTION_W) - 1;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    // action codes the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  word;
        t_err               err;
        logic [COUNT_W-1:0] count;
        logic               full;
        logic               empty;
    } list_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ial_req_if req_ch ();
    ial_rsp_if rsp_ch ();

    indexed_array_list_core #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (DEF_WORD_WIDTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // predicted list contents
    logic [DATA_W-1:0] list_words [CAPACITY];
    int                list_len = 0;
    bit                growing  = 1'b1;

    list_result_t expected_results [$];
    int           fail_count    = 0;
    int           send_idle_pct = 0;
    int           rsp_stall_pct = 0;
    int           quiet_cycles  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic list_result_t apply_request(input logic [ACTION_W-1:0] act,
                                                   input logic [POS_W-1:0]    pos,
                                                   input logic [DATA_W-1:0]   word);
        list_result_t res;
        int           slot;
        res  = '0;
        slot = int'(pos);
        res.err = ERR_OK;
        case (act)
            ACT_PUSH: begin
                if (list_len >= CAPACITY) begin
                    res.err = ERR_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            ACT_POP: begin
                if (list_len > 0) begin
                    list_len--;
                end
            end
            ACT_INSERT: begin
                // the capacity bound is checked before the full condition
                if (slot > CAPACITY) begin
                    res.err = ERR_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.err = ERR_FULL;
                end else if (slot > list_len) begin
                    res.err = ERR_RANGE;
                end else begin
                    for (int i = list_len; i > slot; i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[slot] = word;
                    list_len++;
                end
            end
            ACT_REMOVE: begin
                if (slot >= list_len) begin
                    res.err = ERR_RANGE;
                end else begin
                    for (int i = slot; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                end
            end
            ACT_GET: begin
                if (slot >= list_len) begin
                    res.err = ERR_RANGE;
                end else begin
                    res.word = list_words[slot];
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(list_len);
        res.full  = (list_len == CAPACITY);
        res.empty = (list_len == 0);
        return res;
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [POS_W-1:0]    pos,
                                input logic [DATA_W-1:0]   word);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.word_in  <= word;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        expected_results.push_back(apply_request(act, pos, word));
    endtask

    task automatic test_empty_list();
        send_request(ACT_POP, '0, $urandom());
        send_request(ACT_GET, '0, $urandom());
        send_request(ACT_REMOVE, '0, $urandom());
        send_request(ACT_INSERT, 5'd1, $urandom());
        send_request(ACT_INSERT, POS_W'(CAPACITY + 1), $urandom());
        send_request(ACT_INSERT, POS_W'(POS_MAX), $urandom());
        send_request(ACT_GET, POS_W'(POS_MAX), $urandom());
        for (int c = ACT_SPARE_LO; c <= ACT_SPARE_HI; c++) begin
            send_request(ACTION_W'(c), POS_W'($urandom_range(0, POS_MAX)), $urandom());
        end
    endtask

    task automatic test_fill_and_edit();
        send_request(ACT_PUSH, '0, '0);
        send_request(ACT_PUSH, '0, '1);
        send_request(ACT_INSERT, '0, 32'hA5A5_A5A5);
        send_request(ACT_INSERT, POS_W'(list_len), 32'h5A5A_5A5A);
        send_request(ACT_GET, '0, $urandom());
        send_request(ACT_GET, POS_W'(list_len - 1), $urandom());
        send_request(ACT_REMOVE, '0, $urandom());
        send_request(ACT_REMOVE, POS_W'(list_len - 1), $urandom());
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY) begin
            send_request(ACT_INSERT, POS_W'($urandom_range(0, list_len)), $urandom());
        end
        send_request(ACT_PUSH, '0, $urandom());
        send_request(ACT_INSERT, POS_W'(CAPACITY), $urandom());
        send_request(ACT_INSERT, POS_W'(CAPACITY + 1), $urandom());
        send_request(ACT_INSERT, '0, $urandom());
        send_request(ACT_GET, POS_W'(CAPACITY - 1), $urandom());
        send_request(ACT_GET, POS_W'(CAPACITY), $urandom());
        send_request(ACT_REMOVE, POS_W'(CAPACITY - 1), $urandom());
        send_request(ACT_POP, '0, $urandom());
    endtask

    // list length drifts between empty and full so both ends get exercised
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (n_items) begin
            if (list_len == CAPACITY) begin
                growing = 1'b0;
            end else if (list_len == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                growing = !growing;
            end
            if ($urandom_range(0, 99) < 6) begin
                act = ACTION_W'($urandom_range(0, ACTION_MAX));
                pos = POS_W'($urandom_range(0, POS_MAX));
            end else begin
                pick = $urandom_range(0, 99);
                if (growing) begin
                    act = (pick < 30) ? ACT_PUSH : (pick < 55) ? ACT_INSERT :
                          (pick < 75) ? ACT_GET  : (pick < 90) ? ACT_REMOVE : ACT_POP;
                end else begin
                    act = (pick < 10) ? ACT_PUSH : (pick < 20) ? ACT_INSERT :
                          (pick < 40) ? ACT_GET  : (pick < 70) ? ACT_REMOVE : ACT_POP;
                end
                if (act == ACT_INSERT) begin
                    pos = POS_W'($urandom_range(0, list_len));
                end else if (list_len > 0) begin
                    pos = POS_W'($urandom_range(0, list_len - 1));
                end else begin
                    pos = '0;
                end
            end
            send_request(act, pos, $urandom());
        end
    endtask

    task automatic finish_traffic();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result sink with random backpressure
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.word  = rsp_ch.word_out;
            got.err   = t_err'(rsp_ch.error_code);
            got.count = rsp_ch.entry_count;
            got.full  = rsp_ch.is_full;
            got.empty = rsp_ch.is_empty;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("%0t: result with nothing expected: word %h err %0d count %0d",
                             $realtime, got.word, got.err, got.count);
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: mismatch exp word %h err %0d count %0d full %b empty %b",
                                 $realtime, want.word, want.err, want.count, want.full,
                                 want.empty);
                        $display("%0t:          got word %h err %0d count %0d full %b empty %b",
                                 $realtime, got.word, got.err, got.count, got.full,
                                 got.empty);
                    end
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.action   <= '0;
        req_ch.position <= '0;
        req_ch.word_in  <= '0;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_edit();
        test_full_list();
        test_random_traffic(500, 0, 0);
        test_random_traffic(400, 78, 0);
        test_random_traffic(400, 0, 78);
        test_random_traffic(450, 36, 36);
        finish_traffic();

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
